// ----- rtl/bpst_pkg.sv -----
// bpst_pkg: shared types and constants of the box plane side test
`default_nettype none

package bpst_pkg;

  // bit positions of the side code
  localparam int unsigned SideFrontBit = 0;
  localparam int unsigned SideBackBit  = 1;
  localparam int unsigned SideWidth    = 2;

  // number of axes
  localparam int unsigned NumAxes = 3;

  // per-stage advance enables handed from the top level to the dot units
  typedef struct packed {
    logic s1;  // product stage loads
    logic s2;  // partial sum stage loads
    logic s3;  // compare stage loads
  } bpst_adv_t;

endpackage

`default_nettype wire

// ----- rtl/bpst_if.sv -----
// bpst_if: valid/ready channel interfaces for box plane side test items and results
`default_nettype none

interface bpst_in_if #(
  parameter int unsigned COORD_WIDTH  = 32,
  parameter int unsigned NORMAL_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [COORD_WIDTH-1:0]  box_min_x;
  logic signed [COORD_WIDTH-1:0]  box_min_y;
  logic signed [COORD_WIDTH-1:0]  box_min_z;
  logic signed [COORD_WIDTH-1:0]  box_max_x;
  logic signed [COORD_WIDTH-1:0]  box_max_y;
  logic signed [COORD_WIDTH-1:0]  box_max_z;
  logic signed [NORMAL_WIDTH-1:0] normal_x;
  logic signed [NORMAL_WIDTH-1:0] normal_y;
  logic signed [NORMAL_WIDTH-1:0] normal_z;
  logic signed [COORD_WIDTH-1:0]  plane_dist;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           normal_x, normal_y, normal_z, plane_dist,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           normal_x, normal_y, normal_z, plane_dist,
    output ready
  );
endinterface

interface bpst_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] side_code;

  modport source (
    output valid, side_code,
    input  ready
  );
  modport sink (
    input  valid, side_code,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/box_plane_side_test_core.sv -----
// box_plane_side_test_core: pipelined axis-aligned box against plane side test
//
// Usage: each transaction on in_i carries a box (min and max corners, signed
// Q(COORD_WIDTH-16).16), a plane normal (signed Q2.(NORMAL_WIDTH-2)) and a
// plane distance. Each input transaction yields exactly one transaction on
// out_o with a two-bit side_code: bit0 set when the far corner lies at or in
// front of the plane, bit1 set when the near corner lies behind it.
// Pipeline: corner select, partial products, partial sums, final compare.
// The result is registered through each of these stages in turn. Throughput:
// one transaction per cycle while out_o is not stalled; the multiplier stage
// takes a new item every cycle unless the stage after it is full and blocked.
// Stall: each stage holds while the stage after it is full and blocked, so
// empty stages keep filling and in_i stays ready until the whole pipeline
// holds items; nothing is dropped or repeated.
// Reset: clears all valid bits; the block is ready right after reset.
`default_nettype none

module box_plane_side_test_core #(
  parameter int unsigned COORD_WIDTH  = 32,
  parameter int unsigned NORMAL_WIDTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bpst_in_if.sink   in_i,
  bpst_out_if.source out_o
);

  logic                           v0_q, v1_q, v2_q, v3_q;
  logic                           adv0, adv1, adv2, adv3;
  bpst_pkg::bpst_adv_t            adv;
  logic signed [COORD_WIDTH-1:0]  mn     [bpst_pkg::NumAxes];
  logic signed [COORD_WIDTH-1:0]  mx     [bpst_pkg::NumAxes];
  logic signed [NORMAL_WIDTH-1:0] nrm    [bpst_pkg::NumAxes];
  logic signed [COORD_WIDTH-1:0]  far_d  [bpst_pkg::NumAxes];
  logic signed [COORD_WIDTH-1:0]  near_d [bpst_pkg::NumAxes];
  logic signed [COORD_WIDTH-1:0]  far_q  [bpst_pkg::NumAxes];
  logic signed [COORD_WIDTH-1:0]  near_q [bpst_pkg::NumAxes];
  logic signed [NORMAL_WIDTH-1:0] nrm_q  [bpst_pkg::NumAxes];
  logic signed [COORD_WIDTH-1:0]  dist_q;
  logic                           far_ge;
  logic                           near_ge;

  // stage advance: a stage loads when it is empty or the next one loads
  assign adv3 = ~v3_q | out_o.ready;
  assign adv2 = ~v2_q | adv3;
  assign adv1 = ~v1_q | adv2;
  assign adv0 = ~v0_q | adv1;
  assign adv  = '{s1: adv1, s2: adv2, s3: adv3};

  assign in_i.ready = adv0;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv0) v0_q <= in_i.valid;
      if (adv1) v1_q <= v0_q;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  // far and near corners picked by the sign of each normal component
  always_comb begin
    mn[0]  = in_i.box_min_x;
    mn[1]  = in_i.box_min_y;
    mn[2]  = in_i.box_min_z;
    mx[0]  = in_i.box_max_x;
    mx[1]  = in_i.box_max_y;
    mx[2]  = in_i.box_max_z;
    nrm[0] = in_i.normal_x;
    nrm[1] = in_i.normal_y;
    nrm[2] = in_i.normal_z;
    for (int i = 0; i < bpst_pkg::NumAxes; i++) begin
      if (nrm[i][NORMAL_WIDTH-1]) begin
        far_d[i]  = mn[i];
        near_d[i] = mx[i];
      end else begin
        far_d[i]  = mx[i];
        near_d[i] = mn[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0) begin
      far_q  <= far_d;
      near_q <= near_d;
      nrm_q  <= nrm;
      dist_q <= in_i.plane_dist;
    end
  end

  // far corner dot product against the distance
  bpst_dot #(
    .COORD_WIDTH  (COORD_WIDTH),
    .NORMAL_WIDTH (NORMAL_WIDTH)
  ) u_far_dot (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .coord_i  (far_q),
    .normal_i (nrm_q),
    .dist_i   (dist_q),
    .ge_o     (far_ge)
  );

  // near corner dot product against the distance
  bpst_dot #(
    .COORD_WIDTH  (COORD_WIDTH),
    .NORMAL_WIDTH (NORMAL_WIDTH)
  ) u_near_dot (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .coord_i  (near_q),
    .normal_i (nrm_q),
    .dist_i   (dist_q),
    .ge_o     (near_ge)
  );

  // result transaction
  always_comb begin
    out_o.side_code = '0;
    out_o.side_code[bpst_pkg::SideFrontBit] = far_ge;
    out_o.side_code[bpst_pkg::SideBackBit]  = ~near_ge;
  end

  assign out_o.valid = v3_q;

endmodule

`default_nettype wire

// ----- rtl/bpst_dot.sv -----
// bpst_dot: pipelined exact test of normal . corner >= distance, aligned to the product scale
`default_nettype none

module bpst_dot #(
  parameter int unsigned COORD_WIDTH  = 32,
  parameter int unsigned NORMAL_WIDTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire bpst_pkg::bpst_adv_t            adv_i,
  input  wire logic signed [COORD_WIDTH-1:0]  coord_i  [bpst_pkg::NumAxes],
  input  wire logic signed [NORMAL_WIDTH-1:0] normal_i [bpst_pkg::NumAxes],
  input  wire logic signed [COORD_WIDTH-1:0]  dist_i,
  output logic                                ge_o
);

  // coordinates are split into an unsigned low half and a signed high half
  localparam int unsigned LoW   = COORD_WIDTH / 2;
  localparam int unsigned HiW   = COORD_WIDTH - LoW;
  localparam int unsigned PLoW  = NORMAL_WIDTH + LoW + 1;
  localparam int unsigned PHiW  = NORMAL_WIDTH + HiW;
  localparam int unsigned SLoW  = PLoW + 2;
  localparam int unsigned SHiW  = PHiW + 2;
  localparam int unsigned DiffW = COORD_WIDTH + NORMAL_WIDTH + 3;
  localparam int unsigned Frac  = NORMAL_WIDTH - 2;

  logic signed [PLoW-1:0]        p_lo_d [bpst_pkg::NumAxes];
  logic signed [PLoW-1:0]        p_lo_q [bpst_pkg::NumAxes];
  logic signed [PHiW-1:0]        p_hi_d [bpst_pkg::NumAxes];
  logic signed [PHiW-1:0]        p_hi_q [bpst_pkg::NumAxes];
  logic signed [COORD_WIDTH-1:0] dist1_q;
  logic signed [SLoW-1:0]        s_lo_d;
  logic signed [SLoW-1:0]        s_lo_q;
  logic signed [SHiW-1:0]        s_hi_d;
  logic signed [SHiW-1:0]        s_hi_q;
  logic signed [COORD_WIDTH-1:0] dist2_q;
  logic signed [DiffW-1:0]       diff;
  logic                          ge_d;
  logic                          ge_q;

  // partial products of each axis
  always_comb begin
    for (int i = 0; i < bpst_pkg::NumAxes; i++) begin
      p_lo_d[i] = PLoW'(normal_i[i]) * PLoW'($signed({1'b0, coord_i[i][LoW-1:0]}));
      p_hi_d[i] = PHiW'(normal_i[i]) * PHiW'($signed(coord_i[i][COORD_WIDTH-1:LoW]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      p_lo_q  <= p_lo_d;
      p_hi_q  <= p_hi_d;
      dist1_q <= dist_i;
    end
  end

  // sums of the low and high partial products
  assign s_lo_d = SLoW'(p_lo_q[0]) + SLoW'(p_lo_q[1]) + SLoW'(p_lo_q[2]);
  assign s_hi_d = SHiW'(p_hi_q[0]) + SHiW'(p_hi_q[1]) + SHiW'(p_hi_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      s_lo_q  <= s_lo_d;
      s_hi_q  <= s_hi_d;
      dist2_q <= dist1_q;
    end
  end

  // recombine and subtract the scaled distance, sign gives the compare
  assign diff = (DiffW'(s_hi_q) <<< LoW) + DiffW'(s_lo_q) - (DiffW'(dist2_q) <<< Frac);
  assign ge_d = ~diff[DiffW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ge_q <= 1'b0;
    end else if (adv_i.s3) begin
      ge_q <= ge_d;
    end
  end

  assign ge_o = ge_q;

endmodule

`default_nettype wire

// ----- bench/tb_box_plane_side_test_core.sv -----
// tb_box_plane_side_test_core: self-checking testbench of the box plane side test core
`timescale 1ns / 100ps

module tb_box_plane_side_test_core;

  localparam int unsigned CoordWidth   = 32;
  localparam int unsigned NormalWidth  = 16;
  localparam int unsigned FracShift    = NormalWidth - 2;
  localparam int unsigned PipeLatency  = 3;
  localparam int unsigned DrainCycles  = 4 * PipeLatency + 8;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned IdlePercent  = 15;

  typedef struct packed {
    logic signed [CoordWidth-1:0]  min_x;
    logic signed [CoordWidth-1:0]  min_y;
    logic signed [CoordWidth-1:0]  min_z;
    logic signed [CoordWidth-1:0]  max_x;
    logic signed [CoordWidth-1:0]  max_y;
    logic signed [CoordWidth-1:0]  max_z;
    logic signed [NormalWidth-1:0] n_x;
    logic signed [NormalWidth-1:0] n_y;
    logic signed [NormalWidth-1:0] n_z;
    logic signed [CoordWidth-1:0]  plane_d;
  } box_plane_t;

  logic clk_i;
  logic rst_ni;

  bpst_in_if #(.COORD_WIDTH(CoordWidth), .NORMAL_WIDTH(NormalWidth)) in_if ();
  bpst_out_if out_if ();

  box_plane_side_test_core #(
    .COORD_WIDTH  (CoordWidth),
    .NORMAL_WIDTH (NormalWidth)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [bpst_pkg::SideWidth-1:0] side_exp_q[$];
  logic [bpst_pkg::SideWidth-1:0] side_exp;
  int unsigned                    err_cnt;
  int unsigned                    cycle_cnt;
  bit                             no_idle;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // exact side prediction: far and near corner dots against the aligned distance
  function automatic logic [bpst_pkg::SideWidth-1:0] predict_side(box_plane_t b);
    longint far_dot;
    longint near_dot;
    longint dist_al;
    logic [bpst_pkg::SideWidth-1:0] code;
    far_dot  = 0;
    near_dot = 0;
    code     = '0;
    // x axis; a zero component counts as non-negative
    if (b.n_x < 0) begin
      far_dot  += longint'(b.n_x) * longint'(b.min_x);
      near_dot += longint'(b.n_x) * longint'(b.max_x);
    end else begin
      far_dot  += longint'(b.n_x) * longint'(b.max_x);
      near_dot += longint'(b.n_x) * longint'(b.min_x);
    end
    if (b.n_y < 0) begin
      far_dot  += longint'(b.n_y) * longint'(b.min_y);
      near_dot += longint'(b.n_y) * longint'(b.max_y);
    end else begin
      far_dot  += longint'(b.n_y) * longint'(b.max_y);
      near_dot += longint'(b.n_y) * longint'(b.min_y);
    end
    if (b.n_z < 0) begin
      far_dot  += longint'(b.n_z) * longint'(b.min_z);
      near_dot += longint'(b.n_z) * longint'(b.max_z);
    end else begin
      far_dot  += longint'(b.n_z) * longint'(b.max_z);
      near_dot += longint'(b.n_z) * longint'(b.min_z);
    end
    dist_al = longint'(b.plane_d) <<< FracShift;
    code[bpst_pkg::SideFrontBit] = (far_dot >= dist_al);
    code[bpst_pkg::SideBackBit]  = (near_dot < dist_al);
    return code;
  endfunction

  function automatic box_plane_t make_box(
    logic signed [CoordWidth-1:0] mnx, logic signed [CoordWidth-1:0] mny,
    logic signed [CoordWidth-1:0] mnz, logic signed [CoordWidth-1:0] mxx,
    logic signed [CoordWidth-1:0] mxy, logic signed [CoordWidth-1:0] mxz,
    logic signed [NormalWidth-1:0] nx, logic signed [NormalWidth-1:0] ny,
    logic signed [NormalWidth-1:0] nz, logic signed [CoordWidth-1:0] d);
    box_plane_t b;
    b.min_x = mnx; b.min_y = mny; b.min_z = mnz;
    b.max_x = mxx; b.max_y = mxy; b.max_z = mxz;
    b.n_x   = nx;  b.n_y   = ny;  b.n_z   = nz;
    b.plane_d = d;
    return b;
  endfunction

  // normal component: mostly random, sometimes zero or exactly +-1.0
  function automatic logic signed [NormalWidth-1:0] rand_normal();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return ($urandom_range(0, 1) != 0) ? 16'sh4000 : 16'shc000;
    return NormalWidth'($urandom);
  endfunction

  // random item: mostly a box close to its plane, the rest raw bits or flipped corners
  function automatic box_plane_t rand_box();
    box_plane_t b;
    int unsigned mode;
    longint cx, cy, cz, hx, hy, hz, dot_c, span;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      b = make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   NormalWidth'($urandom), NormalWidth'($urandom), NormalWidth'($urandom),
                   $urandom);
    end else begin
      cx = longint'($signed(CoordWidth'($urandom))) >>> $urandom_range(4, 12);
      cy = longint'($signed(CoordWidth'($urandom))) >>> $urandom_range(4, 12);
      cz = longint'($signed(CoordWidth'($urandom))) >>> $urandom_range(4, 12);
      hx = longint'($urandom_range(0, 32'h0010_0000));
      hy = longint'($urandom_range(0, 32'h0010_0000));
      hz = longint'($urandom_range(0, 32'h0010_0000));
      b.n_x = rand_normal();
      b.n_y = rand_normal();
      b.n_z = rand_normal();
      if (mode == 2) begin
        // corners handed over swapped
        b.min_x = CoordWidth'(cx + hx); b.max_x = CoordWidth'(cx - hx);
        b.min_y = CoordWidth'(cy + hy); b.max_y = CoordWidth'(cy - hy);
        b.min_z = CoordWidth'(cz + hz); b.max_z = CoordWidth'(cz - hz);
      end else begin
        b.min_x = CoordWidth'(cx - hx); b.max_x = CoordWidth'(cx + hx);
        b.min_y = CoordWidth'(cy - hy); b.max_y = CoordWidth'(cy + hy);
        b.min_z = CoordWidth'(cz - hz); b.max_z = CoordWidth'(cz + hz);
      end
      dot_c = (longint'(b.n_x) * cx + longint'(b.n_y) * cy + longint'(b.n_z) * cz) >>> FracShift;
      span  = longint'(1) << $urandom_range(2, 24);
      b.plane_d = CoordWidth'(dot_c + longint'($urandom_range(0, 2 * span)) - span);
    end
    return b;
  endfunction

  // send one transaction, with random idle cycles ahead of it
  task automatic send_box(input box_plane_t b);
    while (!no_idle && ($urandom_range(0, 99) < IdlePercent)) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.box_min_x <= b.min_x;
    in_if.box_min_y <= b.min_y;
    in_if.box_min_z <= b.min_z;
    in_if.box_max_x <= b.max_x;
    in_if.box_max_y <= b.max_y;
    in_if.box_max_z <= b.max_z;
    in_if.normal_x  <= b.n_x;
    in_if.normal_y  <= b.n_y;
    in_if.normal_z  <= b.n_z;
    in_if.plane_dist <= b.plane_d;
    do @(posedge clk_i); while (!in_if.ready);
    side_exp_q.push_back(predict_side(b));
  endtask

  task automatic wait_results_done();
    while (side_exp_q.size() != 0) @(posedge clk_i);
  endtask

  // extremes, exact ties, axial planes, zero components, flipped corners
  task automatic test_directed();
    logic signed [CoordWidth-1:0] lo_c;
    logic signed [CoordWidth-1:0] hi_c;
    logic signed [CoordWidth-1:0] mid_c;
    lo_c  = 32'sd100 <<< 16;
    hi_c  = 32'sd200 <<< 16;
    mid_c = 32'sd150 <<< 16;
    send_box(make_box('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_box(make_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                      32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                      16'sh4000, 16'sh4000, 16'sh4000, '0));
    send_box(make_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                      32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                      16'sh8000, 16'sh8000, 16'sh8000, 32'sh7fff_ffff));
    send_box(make_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                      32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                      16'sh7fff, 16'sh7fff, 16'sh7fff, 32'sh8000_0000));
    send_box(make_box(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                      32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                      16'sh8000, 16'sh8000, 16'sh8000, 32'sh8000_0000));
    send_box(make_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                      32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                      16'sh8000, 16'sh8000, 16'sh8000, 32'sh7fff_ffff));
    // axial plane on x: straddle, ties at both faces, just outside
    send_box(make_box(lo_c, '0, '0, hi_c, '0, '0, 16'sh4000, '0, '0, mid_c));
    send_box(make_box(lo_c, '0, '0, hi_c, '0, '0, 16'sh4000, '0, '0, hi_c));
    send_box(make_box(lo_c, '0, '0, hi_c, '0, '0, 16'sh4000, '0, '0, lo_c));
    send_box(make_box(lo_c, '0, '0, hi_c, '0, '0, 16'sh4000, '0, '0, hi_c + 1));
    send_box(make_box(lo_c, '0, '0, hi_c, '0, '0, 16'sh4000, '0, '0, lo_c - 1));
    // degenerate box sitting on the plane
    send_box(make_box(mid_c, '0, '0, mid_c, '0, '0, 16'sh4000, '0, '0, mid_c));
    // negative axial plane on y picks the minimum as far corner
    send_box(make_box('0, lo_c, '0, '0, hi_c, '0, '0, 16'shc000, '0, -lo_c));
    send_box(make_box('0, lo_c, '0, '0, hi_c, '0, '0, 16'shc000, '0, -mid_c));
    send_box(make_box('0, lo_c, '0, '0, hi_c, '0, '0, 16'shc000, '0, -hi_c - 1));
    // zero components with wild coordinates on those axes
    send_box(make_box(32'sh8000_0000, 32'sh8000_0000, lo_c,
                      32'sh7fff_ffff, 32'sh7fff_ffff, hi_c,
                      '0, '0, 16'sh4000, mid_c));
    // minimum above maximum
    send_box(make_box(hi_c, hi_c, hi_c, lo_c, lo_c, lo_c,
                      16'sh4000, 16'sh4000, 16'sh4000, '0));
    send_box(make_box(hi_c, hi_c, hi_c, lo_c, lo_c, lo_c,
                      16'sh2d41, 16'sh2d41, '0, mid_c));
    // unnormalized normals at the limits
    send_box(make_box(-lo_c, -lo_c, -lo_c, lo_c, lo_c, lo_c,
                      16'sh7fff, 16'sh8000, 16'sh7fff, 32'sh0001_0000));
    send_box(make_box(-lo_c, -lo_c, -lo_c, lo_c, lo_c, lo_c,
                      16'sh0001, 16'shffff, 16'sh0001, 32'shffff_ffff));
  endtask

  task automatic test_random_stalls(input int unsigned n_items);
    for (int unsigned i = 0; i < n_items; i++) send_box(rand_box());
  endtask

  // no idling on either side
  task automatic test_back_to_back(input int unsigned n_items);
    no_idle = 1'b1;
    for (int unsigned i = 0; i < n_items; i++) send_box(rand_box());
    no_idle = 1'b0;
  endtask

  // sender holds off until the pipeline has emptied, then resumes
  task automatic test_drain_resume(input int unsigned n_items);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 75 == 0) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        wait_results_done();
      end
      send_box(rand_box());
    end
  endtask

  // sink side: random backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= no_idle || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (side_exp_q.size() == 0) begin
        $error("side_code: unexpected result, expected none, actual %0d", out_if.side_code);
        err_cnt++;
      end else begin
        side_exp = side_exp_q.pop_front();
        if (out_if.side_code !== side_exp) begin
          $error("side_code: expected %0d, actual %0d", side_exp, out_if.side_code);
          err_cnt++;
        end
      end
    end
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // test sequence
  initial begin
    err_cnt  = 0;
    no_idle  = 1'b0;
    rst_ni   <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.box_min_x  <= '0;
    in_if.box_min_y  <= '0;
    in_if.box_min_z  <= '0;
    in_if.box_max_x  <= '0;
    in_if.box_max_y  <= '0;
    in_if.box_max_z  <= '0;
    in_if.normal_x   <= '0;
    in_if.normal_y   <= '0;
    in_if.normal_z   <= '0;
    in_if.plane_dist <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_stalls(600);
    test_back_to_back(300);
    test_drain_resume(225);

    in_if.valid <= 1'b0;
    wait_results_done();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bpst_pkg.sv
rtl/bpst_if.sv
rtl/bpst_dot.sv
rtl/box_plane_side_test_core.sv
bench/tb_box_plane_side_test_core.sv
